### hw/rtl/tdur_pkg.sv
package tdur_pkg;

  localparam int unsigned HISTORY_DEPTH_DEFAULT = 16;

  localparam logic [4:0] HOUR_MAX       = 5'd23;
  localparam logic [5:0] MINUTE_MAX     = 6'd59;
  localparam logic [7:0] HOURS_PER_DAY  = 8'd24;
  localparam logic [7:0] MINS_PER_HOUR  = 8'd60;

  // Event codes carried in the op field; codes 6 and 7 are unused.
  typedef enum logic [2:0] {
    OP_TICK = 3'd0,
    OP_INC  = 3'd1,
    OP_DEC  = 3'd2,
    OP_SET  = 3'd3,
    OP_UNDO = 3'd4,
    OP_REDO = 3'd5
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } time_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic result_busy;
  } dp_status_t;

  // x mod 24: reciprocal estimate that is at most one low, then one correction.
  function automatic logic [4:0] mod24(input logic [7:0] x);
    logic [14:0] prod;
    logic [7:0]  q;
    logic [7:0]  r;
    prod = 15'(x) * 15'd85;
    q    = 8'(prod >> 11);
    r    = x - 8'(q * HOURS_PER_DAY);
    if (r >= HOURS_PER_DAY) begin
      r = r - HOURS_PER_DAY;
    end
    return r[4:0];
  endfunction

  // x mod 60: same scheme as mod24.
  function automatic logic [5:0] mod60(input logic [7:0] x);
    logic [12:0] prod;
    logic [7:0]  q;
    logic [7:0]  r;
    prod = 13'(x) * 13'd17;
    q    = 8'(prod >> 10);
    r    = x - 8'(q * MINS_PER_HOUR);
    if (r >= MINS_PER_HOUR) begin
      r = r - MINS_PER_HOUR;
    end
    return r[5:0];
  endfunction

endpackage

### hw/rtl/tdur_if.sv
interface tdur_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] new_hours;
  logic [7:0] new_minutes;
  logic [7:0] new_seconds;

  modport source (output valid, op, new_hours, new_minutes, new_seconds, input ready);
  modport sink   (input valid, op, new_hours, new_minutes, new_seconds, output ready);
endinterface

interface tdur_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] hours_now;
  logic [5:0] minutes_now;
  logic [5:0] seconds_now;
  logic       changed;

  modport source (output valid, hours_now, minutes_now, seconds_now, changed, input ready);
  modport sink   (input valid, hours_now, minutes_now, seconds_now, changed, output ready);
endinterface

### hw/rtl/tdur_ctrl.sv
module tdur_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  tdur_pkg::dp_status_t   status_i,
  output tdur_pkg::ctrl_cmd_t    cmd_o
);
  import tdur_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!status_i.result_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_COMMIT: begin
        cmd_o.commit = !status_i.result_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/tdur_dp.sv
module tdur_dp #(
  parameter int unsigned HISTORY_DEPTH = tdur_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tdur_pkg::ctrl_cmd_t    cmd_i,
  output tdur_pkg::dp_status_t   status_o,
  input  logic [2:0]             op_i,
  input  logic [7:0]             new_hours_i,
  input  logic [7:0]             new_minutes_i,
  input  logic [7:0]             new_seconds_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tdur_pkg::time_t        time_o,
  output logic                   changed_o
);
  import tdur_pkg::*;

  localparam int unsigned IdxW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IdxW-1:0]  IdxLast  = IdxW'(HISTORY_DEPTH - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(HISTORY_DEPTH);

  time_t             time_q, time_d;
  logic [FillW-1:0]  undo_fill_q, undo_fill_d;
  logic [IdxW-1:0]   undo_top_q, undo_top_d;
  logic [FillW-1:0]  redo_fill_q, redo_fill_d;

  logic [2:0]        op_q;
  logic [7:0]        new_hours_q, new_minutes_q, new_seconds_q;

  time_t             undo_mem [HISTORY_DEPTH];
  time_t             redo_mem [HISTORY_DEPTH];
  time_t             undo_rd_q, redo_rd_q;
  logic [IdxW-1:0]   undo_rd_addr, redo_rd_addr, redo_wr_addr;
  logic              undo_we, redo_we;

  logic              out_valid_q, out_valid_d;
  time_t             res_q;
  logic              changed_q, changed_d;

  time_t             adv_time, ret_time, set_time;

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q          <= op_i;
      new_hours_q   <= new_hours_i;
      new_minutes_q <= new_minutes_i;
      new_seconds_q <= new_seconds_i;
    end
  end

  assign undo_rd_addr = (undo_top_q == '0) ? IdxLast : undo_top_q - 1'b1;
  assign redo_rd_addr = (redo_fill_q == '0) ? '0 : IdxW'(redo_fill_q - 1'b1);
  assign redo_wr_addr = redo_fill_q[IdxW-1:0];

  // History stores, registered read
  always_ff @(posedge clk_i) begin
    undo_rd_q <= undo_mem[undo_rd_addr];
    redo_rd_q <= redo_mem[redo_rd_addr];
    if (undo_we) begin
      undo_mem[undo_top_q] <= time_q;
    end
    if (redo_we) begin
      redo_mem[redo_wr_addr] <= time_q;
    end
  end

  // One second forward, with carry
  always_comb begin
    adv_time = time_q;
    if (time_q.seconds != MINUTE_MAX) begin
      adv_time.seconds = time_q.seconds + 1'b1;
    end else begin
      adv_time.seconds = '0;
      if (time_q.minutes != MINUTE_MAX) begin
        adv_time.minutes = time_q.minutes + 1'b1;
      end else begin
        adv_time.minutes = '0;
        adv_time.hours   = (time_q.hours >= HOUR_MAX) ? '0 : time_q.hours + 1'b1;
      end
    end
  end

  // One second back, with borrow
  always_comb begin
    ret_time = time_q;
    if (time_q.seconds != '0) begin
      ret_time.seconds = time_q.seconds - 1'b1;
    end else begin
      ret_time.seconds = MINUTE_MAX;
      if (time_q.minutes != '0) begin
        ret_time.minutes = time_q.minutes - 1'b1;
      end else begin
        ret_time.minutes = MINUTE_MAX;
        ret_time.hours   = (time_q.hours != '0) ? time_q.hours - 1'b1 : HOUR_MAX;
      end
    end
  end

  assign set_time.hours   = mod24(new_hours_q);
  assign set_time.minutes = mod60(new_minutes_q);
  assign set_time.seconds = mod60(new_seconds_q);

  always_comb begin
    logic push_undo;
    push_undo   = 1'b0;
    time_d      = time_q;
    undo_fill_d = undo_fill_q;
    undo_top_d  = undo_top_q;
    redo_fill_d = redo_fill_q;
    redo_we     = 1'b0;
    changed_d   = 1'b1;
    case (op_q)
      OP_TICK: time_d = adv_time;
      OP_INC: begin
        push_undo   = 1'b1;
        redo_fill_d = '0;
        time_d      = adv_time;
      end
      OP_DEC: begin
        push_undo   = 1'b1;
        redo_fill_d = '0;
        time_d      = ret_time;
      end
      OP_SET: begin
        push_undo   = 1'b1;
        redo_fill_d = '0;
        time_d      = set_time;
      end
      OP_UNDO: begin
        if (undo_fill_q == '0) begin
          changed_d = 1'b0;
        end else begin
          redo_we     = cmd_i.commit;
          redo_fill_d = redo_fill_q + 1'b1;
          undo_top_d  = undo_rd_addr;
          undo_fill_d = undo_fill_q - 1'b1;
          time_d      = undo_rd_q;
        end
      end
      OP_REDO: begin
        if (redo_fill_q == '0) begin
          changed_d = 1'b0;
        end else begin
          push_undo   = 1'b1;
          redo_fill_d = redo_fill_q - 1'b1;
          time_d      = redo_rd_q;
        end
      end
      default: changed_d = 1'b0;
    endcase
    // Push onto the undo ring; a full ring overwrites its oldest entry.
    if (push_undo) begin
      undo_top_d  = (undo_top_q == IdxLast) ? '0 : undo_top_q + 1'b1;
      undo_fill_d = (undo_fill_q == FillFull) ? undo_fill_q : undo_fill_q + 1'b1;
    end
    undo_we = cmd_i.commit && push_undo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      undo_fill_q <= '0;
      undo_top_q  <= '0;
      redo_fill_q <= '0;
    end else if (cmd_i.commit) begin
      time_q      <= time_d;
      undo_fill_q <= undo_fill_d;
      undo_top_q  <= undo_top_d;
      redo_fill_q <= redo_fill_d;
    end
  end

  // Result register
  assign out_valid_d = cmd_i.commit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q     <= time_d;
      changed_q <= changed_d;
    end
  end

  assign status_o.result_busy = out_valid_q && !out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign time_o               = res_q;
  assign changed_o            = changed_q;

endmodule

### hw/rtl/time_of_day_counter_undo_redo_top.sv
// Time-of-day counter, 24-hour hh:mm:ss, with undo and redo history. Each
// input transaction is one event (tick, increment, decrement, set, undo,
// redo); each produces exactly one result transaction carrying the time
// after the event and a changed flag, which is 0 for undo or redo on an
// empty history and for the unused op codes 6 and 7. Set reduces its
// fields modulo 24/60/60. Increment, decrement and set record the old time
// on the undo ring (a full ring overwrites its oldest entry) and empty the
// redo stack. Time resets to 00:00:00 with both histories empty.
// Each event passes through a capture state and a commit state, and a new
// event is taken only after the previous one has committed. The commit
// step consumes the registered read of the history memories, which is
// launched at capture. Commit waits while the previous result still
// sits unclaimed in the output register; the next event is still taken
// while that result waits.
module time_of_day_counter_undo_redo_top #(
  parameter int unsigned HISTORY_DEPTH = tdur_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdur_in_if.sink     in_ch_i,
  tdur_out_if.source  out_ch_o
);
  import tdur_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  time_t      res_time;

  // Sequence capture and commit of each event.
  tdur_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ch_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold time, history stores and the result register.
  tdur_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .op_i          (in_ch_i.op),
    .new_hours_i   (in_ch_i.new_hours),
    .new_minutes_i (in_ch_i.new_minutes),
    .new_seconds_i (in_ch_i.new_seconds),
    .out_valid_o   (out_ch_o.valid),
    .out_ready_i   (out_ch_o.ready),
    .time_o        (res_time),
    .changed_o     (out_ch_o.changed)
  );

  assign out_ch_o.hours_now   = res_time.hours;
  assign out_ch_o.minutes_now = res_time.minutes;
  assign out_ch_o.seconds_now = res_time.seconds;

endmodule
